FILE: rtl/wbcs_pkg.sv
// Shared types and constants for the white blob column steering block.
// Used by every module under rtl; no dependencies of its own.
`default_nettype none

package wbcs_pkg;

    // Configuration register indexes and widths
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 12;

    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WHITE_LEVEL  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_PEAK     = 2'd3;

    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
    localparam logic [7:0]  WHITE_LEVEL_RST  = 8'd250;
    localparam logic [11:0] MIN_PEAK_RST     = 12'd15;

    // Result field widths
    localparam int CLS_BITS  = 3;
    localparam int Q_BITS    = 15;
    localparam int TURN_BITS = 16;
    localparam int PEAK_BITS = 12;
    localparam int PCOL_BITS = 10;
    localparam int ROW_BITS  = 12;

    typedef logic [CLS_BITS-1:0] yaw_class_t;
    typedef logic [Q_BITS-1:0]   q_frac_t;

    localparam yaw_class_t CLS_LEFT    = 3'd0;
    localparam yaw_class_t CLS_CENTER  = 3'd1;
    localparam yaw_class_t CLS_RIGHT   = 3'd2;
    localparam yaw_class_t CLS_MISSING = 3'd3;
    localparam yaw_class_t CLS_REACHED = 3'd4;

    // Q1.14 unsigned and signed Q2.14 constants
    localparam q_frac_t                     Q_ONE        = 15'd16384;
    localparam logic signed [TURN_BITS-1:0] MISSING_TURN = -16'sd3277;

endpackage

`default_nettype wire

FILE: rtl/white_blob_column_steering.sv
// Top level: configuration registers, pixel column stage and end-of-frame steering.
// Depends on wbcs_pkg, wbcs_column_stage, wbcs_steer_result and wbcs_divider.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   pixel   | in_valid / in_ready  | red, green, blue
//   result  | out_valid/ out_ready | yaw_class, forward_speed, turn_rate,
//           |                      | distance_fraction, peak_count, peak_column
//   config  | write_en             | reg_index, write_data
//
// Pixels flow at one per cycle through a read-modify-write of the column count RAM.
// After the last pixel of a frame the pixel side stalls through the pipeline registers,
// two passes of the shared bit-serial divider and the load state.
// A result waiting on out_ready holds; the next frame's pixels are then taken, but
// that frame's end stalls in the load state until the waiting result leaves.
// Reset clears control state only; the count RAM is rebuilt by each frame's first row.
`default_nettype none

module white_blob_column_steering #(
    parameter int MAX_WIDTH  = 1024,
    parameter int COUNT_BITS = 12
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [7:0]                             red,
    input  wire logic [7:0]                             green,
    input  wire logic [7:0]                             blue,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output wbcs_pkg::yaw_class_t                        yaw_class,
    output wbcs_pkg::q_frac_t                           forward_speed,
    output logic signed [wbcs_pkg::TURN_BITS-1:0]       turn_rate,
    output wbcs_pkg::q_frac_t                           distance_fraction,
    output logic [wbcs_pkg::PEAK_BITS-1:0]              peak_count,
    output logic [wbcs_pkg::PCOL_BITS-1:0]              peak_column,
    input  wire logic                                   write_en,
    input  wire logic [wbcs_pkg::CFG_IDX_BITS-1:0]      reg_index,
    input  wire logic [wbcs_pkg::CFG_DATA_BITS-1:0]     write_data
);
    import wbcs_pkg::*;

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);

    logic [10:0]          frame_width_reg;
    logic [ROW_BITS-1:0]  frame_height_reg;
    logic [7:0]           white_level_reg;
    logic [PEAK_BITS-1:0] min_peak_reg;

    logic [WB-1:0]         width_eff;
    logic [ROW_BITS-1:0]   height_eff;
    logic                  frame_done;
    logic                  res_busy;
    logic [COUNT_BITS-1:0] peak;
    logic [CB-1:0]         peak_col;
    logic [WB-1:0]         empty_cols;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            white_level_reg  <= WHITE_LEVEL_RST;
            min_peak_reg     <= MIN_PEAK_RST;
        end
        else if (write_en)
        begin
            case (reg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= write_data[10:0];
                REG_FRAME_HEIGHT: frame_height_reg <= write_data[ROW_BITS-1:0];
                REG_WHITE_LEVEL:  white_level_reg  <= write_data[7:0];
                REG_MIN_PEAK:     min_peak_reg     <= write_data[PEAK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp width to the supported range; a zero height means one row
    always_comb
    begin
        if (frame_width_reg < 11'd2)
            width_eff = WB'(2);
        else if (int'(frame_width_reg) > MAX_WIDTH)
            width_eff = WB'(MAX_WIDTH);
        else
            width_eff = WB'(frame_width_reg);
        height_eff = (frame_height_reg == '0) ? ROW_BITS'(1) : frame_height_reg;
    end

    wbcs_column_stage #(
        .MAX_WIDTH  (MAX_WIDTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_column_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .width_eff   (width_eff),
        .height_eff  (height_eff),
        .white_level (white_level_reg),
        .res_busy    (res_busy),
        .frame_done  (frame_done),
        .peak        (peak),
        .peak_col    (peak_col),
        .empty_cols  (empty_cols)
    );

    wbcs_steer_result #(
        .MAX_WIDTH  (MAX_WIDTH),
        .COUNT_BITS (COUNT_BITS)
    ) u_steer_result (
        .clk               (clk),
        .rst_n             (rst_n),
        .frame_done        (frame_done),
        .peak              (peak),
        .peak_col          (peak_col),
        .empty_cols        (empty_cols),
        .width_eff         (width_eff),
        .min_peak          (min_peak_reg),
        .busy              (res_busy),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .yaw_class         (yaw_class),
        .forward_speed     (forward_speed),
        .turn_rate         (turn_rate),
        .distance_fraction (distance_fraction),
        .peak_count        (peak_count),
        .peak_column       (peak_column)
    );

endmodule

`default_nettype wire

FILE: rtl/wbcs_divider.sv
// Shared restoring divider: quotient = floor(num * 2^14 / den), num <= den.
// One quotient bit per cycle; depends on wbcs_pkg.
`default_nettype none

module wbcs_divider #(
    parameter int W = 11
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [W-1:0]          num,
    input  wire logic [W-1:0]          den,
    output logic                       done,
    output wbcs_pkg::q_frac_t          quotient
);
    import wbcs_pkg::*;

    localparam int STEP_BITS = $clog2(Q_BITS);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [W-1:0]         rem_reg;
    logic [W-1:0]         den_reg;
    q_frac_t              quo_reg;

    logic [W:0]   trial;
    logic         take;
    logic [W-1:0] rem_next;

    // First step compares the numerator itself, later steps the doubled remainder
    always_comb
    begin
        if (step_reg == '0)
            trial = {1'b0, rem_reg};
        else
            trial = {rem_reg, 1'b0};
        take = trial >= {1'b0, den_reg};
        if (take)
            rem_next = W'(trial - {1'b0, den_reg});
        else
            rem_next = W'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_BITS'(Q_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[Q_BITS-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: rtl/wbcs_column_stage.sv
// Pixel path: raster position, per-column count memory and last-row peak tracking.
// Depends on wbcs_pkg.
`default_nettype none

module wbcs_column_stage #(
    parameter int MAX_WIDTH  = 1024,
    parameter int COUNT_BITS = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [7:0]                        red,
    input  wire logic [7:0]                        green,
    input  wire logic [7:0]                        blue,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]    width_eff,
    input  wire logic [wbcs_pkg::ROW_BITS-1:0]     height_eff,
    input  wire logic [7:0]                        white_level,
    input  wire logic                              res_busy,
    output logic                                   frame_done,
    output logic [COUNT_BITS-1:0]                  peak,
    output logic [$clog2(MAX_WIDTH)-1:0]           peak_col,
    output logic [$clog2(MAX_WIDTH+1)-1:0]         empty_cols
);
    import wbcs_pkg::*;

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);

    logic [COUNT_BITS-1:0] count_mem [MAX_WIDTH];
    logic [COUNT_BITS-1:0] rd_data_reg;

    logic [CB-1:0]       col_reg;
    logic [ROW_BITS-1:0] row_reg;

    logic          s1_valid_reg;
    logic [CB-1:0] s1_col_reg;
    logic          s1_first_reg;
    logic          s1_last_row_reg;
    logic          s1_end_reg;
    logic          s1_white_reg;
    logic          frame_done_reg;

    logic [COUNT_BITS-1:0] peak_reg;
    logic [CB-1:0]         peak_col_reg;
    logic [WB-1:0]         empty_reg;

    logic                  accept;
    logic                  white;
    logic                  last_col;
    logic                  last_row;
    logic [COUNT_BITS-1:0] cnt;

    assign accept   = in_valid && in_ready;
    assign in_ready = !(s1_valid_reg && s1_end_reg) && !frame_done_reg && !res_busy;
    assign white    = (red >= white_level) && (green >= white_level) &&
                      (blue >= white_level);
    assign last_col = WB'(col_reg) >= (width_eff - 1'b1);
    assign last_row = row_reg >= (height_eff - 1'b1);

    // The first row restarts the column, later rows add with saturation
    always_comb
    begin
        if (s1_first_reg)
            cnt = COUNT_BITS'(s1_white_reg);
        else if (s1_white_reg && (rd_data_reg != {COUNT_BITS{1'b1}}))
            cnt = rd_data_reg + 1'b1;
        else
            cnt = rd_data_reg;
    end

    // Neighbouring beats never share a column, so read and write need no bypass
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
            count_mem[s1_col_reg] <= cnt;
        if (accept)
            rd_data_reg <= count_mem[col_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            s1_valid_reg    <= 1'b0;
            s1_end_reg      <= 1'b0;
            frame_done_reg  <= 1'b0;
            peak_reg        <= '0;
            peak_col_reg    <= '0;
            empty_reg       <= '0;
        end
        else
        begin
            s1_valid_reg   <= accept;
            frame_done_reg <= s1_valid_reg && s1_end_reg;
            if (accept)
            begin
                s1_end_reg <= last_col && last_row;
                if (!last_col)
                    col_reg <= col_reg + 1'b1;
                else
                begin
                    col_reg <= '0;
                    if (!last_row)
                        row_reg <= row_reg + 1'b1;
                    else
                        row_reg <= '0;
                end
            end
            else
                s1_end_reg <= 1'b0;

            if (s1_valid_reg && s1_last_row_reg)
            begin
                if (s1_col_reg == '0)
                begin
                    peak_reg     <= cnt;
                    peak_col_reg <= '0;
                    empty_reg    <= WB'(cnt == '0);
                end
                else
                begin
                    if (cnt > peak_reg)
                    begin
                        peak_reg     <= cnt;
                        peak_col_reg <= s1_col_reg;
                    end
                    if (cnt == '0)
                        empty_reg <= empty_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg      <= col_reg;
            s1_first_reg    <= row_reg == '0;
            s1_last_row_reg <= last_row;
            s1_white_reg    <= white;
        end
    end

    assign frame_done = frame_done_reg;
    assign peak       = peak_reg;
    assign peak_col   = peak_col_reg;
    assign empty_cols = empty_reg;

endmodule

`default_nettype wire

FILE: rtl/wbcs_steer_result.sv
// End-of-frame sequencer: class decision, two divisions and the result register.
// Depends on wbcs_pkg and wbcs_divider.
`default_nettype none

module wbcs_steer_result #(
    parameter int MAX_WIDTH  = 1024,
    parameter int COUNT_BITS = 12
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 frame_done,
    input  wire logic [COUNT_BITS-1:0]                peak,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]         peak_col,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       empty_cols,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       width_eff,
    input  wire logic [wbcs_pkg::PEAK_BITS-1:0]       min_peak,
    output logic                                      busy,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output wbcs_pkg::yaw_class_t                      yaw_class,
    output wbcs_pkg::q_frac_t                         forward_speed,
    output logic signed [wbcs_pkg::TURN_BITS-1:0]     turn_rate,
    output wbcs_pkg::q_frac_t                         distance_fraction,
    output logic [wbcs_pkg::PEAK_BITS-1:0]            peak_count,
    output logic [wbcs_pkg::PCOL_BITS-1:0]            peak_column
);
    import wbcs_pkg::*;

    localparam int CB = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int PW = (COUNT_BITS > PEAK_BITS) ? COUNT_BITS : PEAK_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIST = 2'd1;
    localparam logic [1:0] ST_TURN = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0]            state_reg;
    logic                  start_reg;
    yaw_class_t            cls_reg;
    logic [WB-1:0]         dist_num_reg;
    logic [WB-1:0]         turn_num_reg;
    logic [WB-1:0]         mid_reg;
    logic [WB-1:0]         den_reg;
    q_frac_t               dist_reg;
    logic [COUNT_BITS-1:0] peak_hold_reg;
    logic [CB-1:0]         col_hold_reg;

    logic                  out_valid_reg;
    yaw_class_t            yaw_class_reg;
    q_frac_t               forward_reg;
    logic signed [TURN_BITS-1:0] turn_reg;
    q_frac_t               distance_reg;
    logic [PEAK_BITS-1:0]  peak_count_reg;
    logic [PCOL_BITS-1:0]  peak_column_reg;

    logic [WB-1:0]   occupied;
    logic [WB:0]     twice;
    logic            reached;
    logic [WB-1:0]   mid;
    logic [WB-1:0]   col_ext;
    logic [WB-1:0]   diff;
    logic            seen;
    logic [WB+2:0]   five_col;
    logic [WB+2:0]   two_w;
    logic [WB+2:0]   three_w;
    yaw_class_t      cls;

    logic [WB-1:0] div_num;
    logic [WB-1:0] div_den;
    logic          div_done;
    q_frac_t       div_quo;
    logic          load;
    logic signed [TURN_BITS-1:0] turn_val;

    // Frame summary to class and division operands
    always_comb
    begin
        occupied = (empty_cols >= width_eff) ? '0 : (width_eff - empty_cols);
        twice    = {occupied, 1'b0};
        reached  = twice >= {1'b0, width_eff};
        mid      = width_eff >> 1;
        col_ext  = WB'(peak_col);
        diff     = (mid > col_ext) ? (mid - col_ext) : (col_ext - mid);
        // Beyond the midpoint distance the turn saturates at one
        if (diff > mid)
            diff = mid;
        seen     = PW'(peak) >= PW'(min_peak);
        five_col = (WB+3)'(col_ext) * 3'd5;
        two_w    = (WB+3)'(width_eff) << 1;
        three_w  = (WB+3)'(width_eff) * 2'd3;
        if (reached)
            cls = CLS_REACHED;
        else if (!seen)
            cls = CLS_MISSING;
        else if (five_col < two_w)
            cls = CLS_LEFT;
        else if (five_col > three_w)
            cls = CLS_RIGHT;
        else
            cls = CLS_CENTER;
    end

    assign div_num = (state_reg == ST_DIST) ? dist_num_reg : turn_num_reg;
    assign div_den = (state_reg == ST_DIST) ? den_reg : mid_reg;

    wbcs_divider #(
        .W (WB)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .num      (div_num),
        .den      (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign load = (state_reg == ST_LOAD) && (!out_valid_reg || out_ready);

    always_comb
    begin
        case (cls_reg)
            CLS_LEFT:    turn_val = TURN_BITS'(div_quo);
            CLS_RIGHT:   turn_val = TURN_BITS'(0) - TURN_BITS'(div_quo);
            CLS_MISSING: turn_val = MISSING_TURN;
            default:     turn_val = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (frame_done)
                    begin
                        state_reg <= ST_DIST;
                        start_reg <= 1'b1;
                    end
                end
                ST_DIST:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_TURN;
                        start_reg <= 1'b1;
                    end
                end
                ST_TURN:
                begin
                    if (div_done)
                        state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    if (load)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase

            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && frame_done)
        begin
            cls_reg       <= cls;
            dist_num_reg  <= reached ? '0 : WB'({1'b0, width_eff} - twice);
            turn_num_reg  <= diff;
            mid_reg       <= mid;
            den_reg       <= width_eff;
            peak_hold_reg <= peak;
            col_hold_reg  <= peak_col;
        end
        if ((state_reg == ST_DIST) && div_done)
            dist_reg <= div_quo;
        if ((state_reg == ST_TURN) && div_done)
            turn_reg <= turn_val;
        if (load)
        begin
            yaw_class_reg   <= cls_reg;
            forward_reg     <= (cls_reg == CLS_CENTER) ? Q_ONE : '0;
            distance_reg    <= dist_reg;
            peak_count_reg  <= PEAK_BITS'(peak_hold_reg);
            peak_column_reg <= PCOL_BITS'(col_hold_reg);
        end
    end

    // turn_reg is final before the load, so drive the port from a copy taken at load
    logic signed [TURN_BITS-1:0] turn_out_reg;

    always_ff @(posedge clk)
    begin
        if (load)
            turn_out_reg <= turn_reg;
    end

    assign busy              = state_reg != ST_IDLE;
    assign out_valid         = out_valid_reg;
    assign yaw_class         = yaw_class_reg;
    assign forward_speed     = forward_reg;
    assign turn_rate         = turn_out_reg;
    assign distance_fraction = distance_reg;
    assign peak_count        = peak_count_reg;
    assign peak_column       = peak_column_reg;

endmodule

`default_nettype wire
